// File: rtl/mvmp_pkg.sv
// package for the modular vector-matrix product block
// shared widths, state encoding and the configuration register indexes
`timescale 1ns / 1ps

package mvmp_pkg;

	localparam int MaxCols  = 64;
	localparam int ColW     = $clog2(MaxCols);
	localparam int WordW    = 64;
	localparam int NumColsW = 7;

	localparam logic [0:0] RegModulus = 1'b0;
	localparam logic [0:0] RegNumCols = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_RED  = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

// File: rtl/modular_vector_matrix_product.sv
// modular vector-matrix product, top level
// uses mvmp_pkg, mvmp_ram, mvmp_mulmod, mvmp_redmod
//
// usage: one input item per matrix entry, row-major; tdata holds coef (63:0),
// entry (127:64), tuser holds final_row. on items of the final row one result
// item leaves on the master side: tdata holds col_index (5:0) and residue
// (69:6), tlast marks the last column.
// configuration: cfg_valid/cfg_ready with cfg_index (0 modulus, 1 num_cols)
// and cfg_data; cfg_ready is held high, write only while no item is in flight.
// operation: a serial reduction of entry mod n (skipped for a zero modulus)
// and a shift-and-add multiply run in one shared serial unit, a serial
// reduction of the stored column sum runs in parallel with them, then the
// product is registered and the accumulate state adds and writes back.
// an item is taken only while the block is idle and the result register is
// free, so a new item is not taken before the last one is through.
// reset: modulus 1, column count 1, column counter 0, new product pending.
// column sums live in a 64-entry ram and are not cleared.
// a stalled receiver holds the result in the output register; the input
// stays blocked until it is taken.
`timescale 1ns / 1ps

module modular_vector_matrix_product (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // coef, entry
	input  logic         s_axis_tuser,  // final_row
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // col_index, residue, zero fill
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int W = mvmp_pkg::WordW;
	localparam int CW = mvmp_pkg::ColW;

	mvmp_pkg::state_t state_q;
	logic [W-1:0]     modulus_q;
	logic [mvmp_pkg::NumColsW-1:0] num_cols_q;
	logic [CW-1:0]    col_q, col_s1;
	logic             first_q, final_s1, rowend_s1;
	logic             mul_done, red_done, mul_got_q, red_got_q;
	logic [W-1:0]     prod, red, prod_q, red_q, sum;
	logic [W-1:0]     ram_rdata;
	logic             start_s;
	logic [mvmp_pkg::NumColsW-1:0] cols;
	logic [CW-1:0]    col_in;
	logic             ovalid_q, olast_q;
	logic [CW-1:0]    ocol_q;
	logic [W-1:0]     ores_q;
	logic             in_fire;
	logic             red_start_q;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == mvmp_pkg::ST_IDLE) && !ovalid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (num_cols_q == '0) begin
			cols = 7'd1;
		end else if (num_cols_q > 7'(mvmp_pkg::MaxCols)) begin
			cols = 7'(mvmp_pkg::MaxCols);
		end else begin
			cols = num_cols_q;
		end
		col_in = ({1'b0, col_q} >= cols) ? '0 : col_q;
	end

	mvmp_ram #(.Width(W), .Depth(mvmp_pkg::MaxCols)) u_sums (
		.clk   (clk),
		.we    (state_q == mvmp_pkg::ST_ACC),
		.waddr (col_s1),
		.wdata (sum),
		.raddr (in_fire ? col_in : col_s1),
		.rdata (ram_rdata)
	);

	mvmp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_s),
		.x      (s_axis_tdata[63:0]),
		.y      (s_axis_tdata[127:64]),
		.n      (modulus_q),
		.done   (mul_done),
		.prod   (prod)
	);

	mvmp_redmod u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == mvmp_pkg::ST_MUL && !red_got_q && !mul_got_q && red_start_q),
		.x      (ram_rdata),
		.n      (modulus_q),
		.done   (red_done),
		.rem    (red)
	);

	assign start_s = in_fire;

	always_comb begin
		logic [W:0] s;
		s = {1'b0, red_q} + {1'b0, prod_q};
		if (first_q) begin
			sum = prod_q;
		end else if (modulus_q == '0) begin
			sum = s[W-1:0];
		end else if (s[W] || s[W-1:0] >= modulus_q) begin
			sum = W'(s - {1'b0, modulus_q});
		end else begin
			sum = s[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvmp_pkg::ST_IDLE;
			modulus_q   <= 64'd1;
			num_cols_q  <= 7'd1;
			col_q       <= '0;
			first_q     <= 1'b1;
			ovalid_q    <= 1'b0;
			mul_got_q   <= 1'b0;
			red_got_q   <= 1'b0;
			red_start_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mvmp_pkg::RegModulus) begin
					modulus_q <= cfg_data;
				end else begin
					num_cols_q <= cfg_data[mvmp_pkg::NumColsW-1:0];
				end
			end
			if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			red_start_q <= 1'b0;
			case (state_q)
				mvmp_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q     <= mvmp_pkg::ST_MUL;
						mul_got_q   <= 1'b0;
						red_got_q   <= first_q;
						red_start_q <= !first_q;
					end
				end
				mvmp_pkg::ST_MUL: begin
					if (mul_done) begin
						mul_got_q <= 1'b1;
					end
					if (red_done) begin
						red_got_q <= 1'b1;
					end
					if ((mul_got_q || mul_done) && (red_got_q || red_done)) begin
						state_q <= mvmp_pkg::ST_ACC;
					end
				end
				mvmp_pkg::ST_ACC: begin
					state_q <= mvmp_pkg::ST_IDLE;
					if (rowend_s1) begin
						col_q   <= '0;
						first_q <= final_s1;
					end else begin
						col_q <= col_s1 + 1'b1;
					end
					if (final_s1) begin
						ovalid_q <= 1'b1;
					end
				end
				default: state_q <= mvmp_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1    <= col_in;
			final_s1  <= s_axis_tuser;
			rowend_s1 <= ({1'b0, col_in} + 7'd1) >= cols;
		end
		if (mul_done) begin
			prod_q <= prod;
		end
		if (red_done) begin
			red_q <= red;
		end
		if (state_q == mvmp_pkg::ST_ACC) begin
			ocol_q  <= col_s1;
			ores_q  <= sum;
			olast_q <= rowend_s1;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {2'b00, ores_q, ocol_q};
	assign m_axis_tlast  = olast_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mvmp_pkg::ST_IDLE) |-> !s_axis_tready)
		else $error("input taken while busy");

	a_result_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(final_s1))
		else $error("result without final row");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mvmp_pkg::ST_ACC) |-> ({1'b0, col_s1} < cols) || $past(cfg_valid))
		else $error("column out of range");

endmodule

// File: rtl/mvmp_ram.sv
// generic single-port-write, registered-read memory
// no dependencies
`timescale 1ns / 1ps

module mvmp_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mvmp_mulmod.sv
// sequential modular multiplier, one bit of the multiplier per cycle
// uses mvmp_pkg
`timescale 1ns / 1ps

module mvmp_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mvmp_pkg::WordW-1:0] x,
	input  logic [mvmp_pkg::WordW-1:0] y,
	input  logic [mvmp_pkg::WordW-1:0] n,
	output logic                      done,
	output logic [mvmp_pkg::WordW-1:0] prod
);

	localparam int W = mvmp_pkg::WordW;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_RED  = 3'b010,
		M_MUL  = 3'b100
	} mstate_t;

	mstate_t        state_q;
	logic [W-1:0]   x_q, e_q, n_q, r_q, rem_q;
	logic [W:0]     div_q;
	logic [6:0]     bit_q;
	logic [W-1:0]   dbl, dsum;
	logic [W:0]     remsh;
	logic [W-1:0]   remnext;

	// one bit of y mod n by restoring division, msb first
	always_comb begin
		remsh = {rem_q, div_q[W]};
		remnext = (remsh >= {1'b0, n_q}) ? W'(remsh - {1'b0, n_q}) : remsh[W-1:0];
	end

	function automatic logic [W-1:0] addm(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (m == '0) begin
			return s[W-1:0];
		end
		if (s[W] || s[W-1:0] >= m) begin
			return W'(s - {1'b0, m});
		end
		return s[W-1:0];
	endfunction

	always_comb begin
		dbl  = addm(r_q, r_q, n_q);
		dsum = x_q[W-1] ? addm(dbl, e_q, n_q) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= (n == '0) ? M_MUL : M_RED;
					end
				end
				M_RED: begin
					if (bit_q == 7'(W - 1)) begin
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (bit_q == 7'(W - 1)) begin
						state_q <= M_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				x_q   <= x;
				e_q   <= y;
				n_q   <= n;
				div_q <= {y, 1'b0};
				rem_q <= '0;
				r_q   <= '0;
				bit_q <= '0;
			end
			M_RED: begin
				rem_q <= remnext;
				div_q <= {div_q[W-1:0], 1'b0};
				bit_q <= (bit_q == 7'(W - 1)) ? 7'd0 : bit_q + 7'd1;
				if (bit_q == 7'(W - 1)) begin
					e_q <= remnext;
				end
			end
			M_MUL: begin
				r_q   <= dsum;
				x_q   <= {x_q[W-2:0], 1'b0};
				bit_q <= bit_q + 7'd1;
			end
			default: ;
		endcase
	end

	assign prod = r_q;

endmodule

// File: rtl/mvmp_redmod.sv
// sequential reduction of a stored word modulo n, one bit per cycle
// uses mvmp_pkg
`timescale 1ns / 1ps

module mvmp_redmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mvmp_pkg::WordW-1:0] x,
	input  logic [mvmp_pkg::WordW-1:0] n,
	output logic                      done,
	output logic [mvmp_pkg::WordW-1:0] rem
);

	localparam int W = mvmp_pkg::WordW;

	logic           busy_q;
	logic [W-1:0]   n_q, rem_q;
	logic [W:0]     div_q;
	logic [6:0]     bit_q;
	logic [W:0]     remsh;
	logic [W-1:0]   remnext;

	always_comb begin
		remsh = {rem_q, div_q[W]};
		remnext = (remsh >= {1'b0, n_q}) ? W'(remsh - {1'b0, n_q}) : remsh[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					if (n == '0) begin
						done <= 1'b1;
					end else begin
						busy_q <= 1'b1;
					end
				end
			end else if (bit_q == 7'(W - 1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			n_q   <= n;
			div_q <= {x, 1'b0};
			rem_q <= (n == '0) ? x : '0;
			bit_q <= '0;
		end else begin
			rem_q <= remnext;
			div_q <= {div_q[W-1:0], 1'b0};
			bit_q <= bit_q + 7'd1;
		end
	end

	assign rem = rem_q;

endmodule

// File: tb/sv/mvmp_checker.sv
// checker for the modular vector-matrix product block
// watches the input, result and register channels, predicts residues, compares
// depends on mvmp_pkg
`timescale 1ns / 1ps

module mvmp_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // coef, entry
	input  logic         s_axis_tuser,  // final_row
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [71:0]  m_axis_tdata,  // col_index, residue, zero fill
	input  logic         m_axis_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam int ColW     = mvmp_pkg::ColW;
	localparam int WordW    = mvmp_pkg::WordW;
	localparam int NumColsW = mvmp_pkg::NumColsW;
	localparam int MaxCols  = mvmp_pkg::MaxCols;

	typedef struct packed {
		logic [ColW-1:0]  col;
		logic [WordW-1:0] residue;
		logic             last_col;
	} column_result_t;

	column_result_t   residue_queue[$];
	logic [WordW-1:0] modulus_q;
	logic [NumColsW-1:0] num_cols_q;
	logic [WordW-1:0] col_sum[MaxCols];
	int               col_ptr;
	logic             new_product;

	function automatic logic [WordW-1:0] reduce_word(logic [WordW-1:0] x, logic [WordW-1:0] n);
		return (n == 0) ? x : x % n;
	endfunction

	function automatic logic [WordW-1:0] product_mod(logic [WordW-1:0] a, logic [WordW-1:0] b,
			logic [WordW-1:0] n);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return (n == 0) ? p[63:0] : WordW'(p % {64'b0, n});
	endfunction

	function automatic logic [WordW-1:0] sum_mod(logic [WordW-1:0] a, logic [WordW-1:0] b,
			logic [WordW-1:0] n);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (n == 0) ? s[63:0] : WordW'(s % {1'b0, n});
	endfunction

	assign pending = residue_queue.size();

	always @(posedge clk or negedge arst_n) begin
		int               cols;
		int               col;
		logic [WordW-1:0] prod;
		logic [WordW-1:0] acc;
		logic             row_done;
		column_result_t   got;
		column_result_t   want;
		if (!arst_n) begin
			modulus_q   <= 1;
			num_cols_q  <= 1;
			col_ptr     <= 0;
			new_product <= 1'b1;
			residue_queue.delete();
			fail_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mvmp_pkg::RegModulus)
					modulus_q <= cfg_data;
				else if (cfg_index == mvmp_pkg::RegNumCols)
					num_cols_q <= cfg_data[NumColsW-1:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cols = (num_cols_q == 0) ? 1 : (num_cols_q > MaxCols) ? MaxCols : int'(num_cols_q);
				col  = (col_ptr >= cols) ? 0 : col_ptr;
				prod = product_mod(s_axis_tdata[63:0], s_axis_tdata[127:64], modulus_q);
				acc  = new_product ? prod
					: sum_mod(reduce_word(col_sum[col], modulus_q), prod, modulus_q);
				col_sum[col] <= acc;
				row_done = (col + 1 >= cols);
				if (row_done) begin
					col_ptr     <= 0;
					new_product <= s_axis_tuser;
				end else begin
					col_ptr <= col + 1;
				end
				if (s_axis_tuser)
					residue_queue.push_back('{col: ColW'(col), residue: acc, last_col: row_done});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{col: m_axis_tdata[5:0], residue: m_axis_tdata[69:6],
					last_col: m_axis_tlast};
				if (residue_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: col %0d residue %h last %b",
							got.col, got.residue, got.last_col);
					fail_count <= fail_count + 1;
				end else begin
					want = residue_queue.pop_front();
					if (got != want || m_axis_tdata[71:70] != 0) begin
						if (fail_count < 10)
							$display(
								"mismatch: exp col %0d res %h last %b, got col %0d res %h last %b fill %b",
								want.col, want.residue, want.last_col,
								got.col, got.residue, got.last_col, m_axis_tdata[71:70]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: tb/sv/tb.sv
// testbench top for the modular vector-matrix product block
// drives entries and register writes, gives the verdict; depends on mvmp_pkg,
// mvmp_checker and the block itself
`timescale 1ns / 1ps

module tb;

	localparam int IdleLimit = 4000;
	localparam int SettleCycles = 200;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // coef, entry
	logic         s_axis_tuser = 1'b0;  // final_row
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;  // col_index, residue, zero fill
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [0:0]   cfg_index = mvmp_pkg::RegModulus;
	logic [63:0]  cfg_data = '0;

	int           fail_count;
	int           pending;
	int           idle_cycles = 0;
	int           entries_sent = 0;
	logic         steady = 1'b0;
	logic [63:0]  cur_modulus = 1;
	int           cur_cols = 1;

	always #10 clk = ~clk;

	modular_vector_matrix_product u_dut (.*);

	mvmp_checker u_checker (.*);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int stall;
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_entry(input logic [63:0] coef, input logic [63:0] entry,
			input logic final_row);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {entry, coef};
		s_axis_tuser  = final_row;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		entries_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == mvmp_pkg::RegModulus) begin
			cur_modulus = value;
		end else begin
			cur_cols = (value[6:0] == 0) ? 1
				: (value[6:0] > mvmp_pkg::MaxCols) ? mvmp_pkg::MaxCols : int'(value[6:0]);
		end
	endtask

	function automatic logic [63:0] pick_word();
		logic [63:0] w;
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = 64'($urandom_range(0, 15));
			3: w = (cur_modulus != 0) ? cur_modulus - 1 : '1;
			default: w = {$urandom, $urandom};
		endcase
		if (cur_modulus != 0 && $urandom_range(0, 1) == 1)
			w = w % cur_modulus;
		return w;
	endfunction

	function automatic logic [63:0] pick_modulus();
		case ($urandom_range(0, 6))
			0: return 64'd0;
			1: return 64'd1;
			2: return '1;
			3: return {1'b1, 31'($urandom), $urandom};
			4: return 64'($urandom_range(2, 1000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic run_product(input int rows, input logic ragged);
		logic [63:0] coef;
		logic        fin;
		for (int r = 0; r < rows; r++) begin
			coef = pick_word();
			for (int c = 0; c < cur_cols; c++) begin
				fin = (r == rows - 1);
				if (ragged && !fin && $urandom_range(0, 3) == 0)
					fin = 1'($urandom_range(0, 1));
				send_entry(coef, pick_word(), fin);
			end
		end
	endtask

	initial begin
		logic [63:0] cols_value;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: modulus 1, one column
		send_entry('1, '1, 1'b1);
		wait_idle();

		// zero modulus wraps at 2^64
		write_reg(mvmp_pkg::RegModulus, 64'd0);
		write_reg(mvmp_pkg::RegNumCols, 64'd2);
		send_entry('1, '1, 1'b0);
		send_entry('1, 64'd3, 1'b0);
		send_entry(64'd2, 64'd5, 1'b1);
		send_entry(64'd1, '1, 1'b1);
		wait_idle();

		// largest modulus, operands at and near it
		write_reg(mvmp_pkg::RegModulus, '1);
		write_reg(mvmp_pkg::RegNumCols, 64'd1);
		send_entry('1, '1, 1'b1);
		send_entry(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		wait_idle();

		// stored sum above a new smaller modulus
		write_reg(mvmp_pkg::RegModulus, 64'd0);
		send_entry('1, 64'd1, 1'b0);
		wait_idle();
		write_reg(mvmp_pkg::RegModulus, 64'd7);
		send_entry(64'd3, 64'd1, 1'b1);
		wait_idle();

		// column count lowered mid-row
		write_reg(mvmp_pkg::RegModulus, 64'd1000003);
		write_reg(mvmp_pkg::RegNumCols, 64'd3);
		send_entry(64'd5, 64'd6, 1'b0);
		send_entry(64'd7, 64'd8, 1'b0);
		wait_idle();
		write_reg(mvmp_pkg::RegNumCols, 64'd2);
		send_entry(64'd1, 64'd1, 1'b1);
		send_entry(64'd2, 64'd2, 1'b1);
		wait_idle();

		// zero column count acts as one
		write_reg(mvmp_pkg::RegNumCols, 64'd0);
		send_entry(64'd9, 64'd9, 1'b1);
		wait_idle();

		// final flag changing inside a row
		write_reg(mvmp_pkg::RegModulus, 64'd97);
		write_reg(mvmp_pkg::RegNumCols, 64'd2);
		send_entry(64'd50, 64'd60, 1'b1);
		send_entry(64'd70, 64'd80, 1'b0);
		send_entry(64'd11, 64'd12, 1'b0);
		send_entry(64'd13, 64'd14, 1'b1);
		wait_idle();

		while (entries_sent < 380) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(mvmp_pkg::RegModulus, pick_modulus());
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 9))
					0: cols_value = 64'd0;
					1: cols_value = 64'($urandom_range(65, 127)) | ({$urandom, 25'd0} << 7);
					2: cols_value = 64'($urandom_range(9, 64));
					default: cols_value = 64'($urandom_range(1, 8)) | ({$urandom, 25'd0} << 7);
				endcase
				write_reg(mvmp_pkg::RegNumCols, cols_value);
			end
			steady = ($urandom_range(0, 4) == 0);
			run_product((cur_cols > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4),
				$urandom_range(0, 5) == 0);
			steady = 1'b0;
			wait_idle();
		end

		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
